// ===== sv/msc_pkg.sv =====
// ----------------------------------------------------------------------------
// msc_pkg: shared types and constants for the minicomputer subset core
// Sequencer states, instruction classes, request and result codes, decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package msc_pkg;

    localparam int unsigned MEMORY_BYTES_DEF = 65536;
    localparam logic [15:0] START_RESET      = 16'o001000;

    // request opcodes
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_STEP  = 2'd2;

    // result status codes
    localparam logic [2:0] ST_DONE    = 3'd0;
    localparam logic [2:0] ST_EXEC    = 3'd1;
    localparam logic [2:0] ST_HALT    = 3'd2;
    localparam logic [2:0] ST_UNKNOWN = 3'd3;
    localparam logic [2:0] ST_IGNORED = 3'd4;

    // opcode masks and patterns
    localparam logic [15:0] MASK_TOP4 = 16'o170000;
    localparam logic [15:0] MASK_SOB  = 16'o177000;
    localparam logic [15:0] MASK_ONE  = 16'o177700;
    localparam logic [15:0] MASK_BR   = 16'o177400;
    localparam logic [15:0] MASK_RTS  = 16'o177770;
    localparam logic [15:0] CODE_MOV  = 16'o010000;
    localparam logic [15:0] CODE_MOVB = 16'o110000;
    localparam logic [15:0] CODE_ADD  = 16'o060000;
    localparam logic [15:0] CODE_SOB  = 16'o077000;
    localparam logic [15:0] CODE_CLR  = 16'o005000;
    localparam logic [15:0] CODE_JMP  = 16'o000100;
    localparam logic [15:0] CODE_BR   = 16'o000400;
    localparam logic [15:0] CODE_BEQ  = 16'o001400;
    localparam logic [15:0] CODE_RTS  = 16'o000200;
    localparam logic [15:0] CODE_JSR  = 16'o004000;
    localparam logic [15:0] CODE_TSTB = 16'o105700;
    localparam logic [15:0] CODE_BPL  = 16'o100000;

    typedef enum logic [3:0] {
        I_MOV, I_MOVB, I_ADD, I_HALT, I_SOB, I_CLR, I_JMP, I_BR,
        I_BEQ, I_RTS, I_JSR, I_TSTB, I_BPL, I_UNK
    } instr_t;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_FETCH, S_DECODE,
        S_SRC_GET, S_SRC_LATCH, S_DST, S_DST_RES, S_DST_GET, S_DST_LATCH,
        S_DST_USE, S_WRITE,
        S_JSR1, S_JSR2, S_JSR3, S_JSR4, S_RTS1, S_RTS2, S_RTS3,
        S_SOB1, S_SOB2, S_BRANCH,
        S_RES_A, S_RES_IDX, S_RES_DEF,
        S_M_MOD, S_M_RD_LO, S_M_RD_HI, S_M_RD_END, S_M_WR_LO, S_M_WR_HI,
        S_DONE
    } state_t;

    function automatic instr_t decode_instr(input logic [15:0] w);
        instr_t c;
        c = I_UNK;
        if ((w & MASK_TOP4) == CODE_MOV)
            c = I_MOV;
        else if ((w & MASK_TOP4) == CODE_MOVB)
            c = I_MOVB;
        else if ((w & MASK_TOP4) == CODE_ADD)
            c = I_ADD;
        else if (w == 16'd0)
            c = I_HALT;
        else if ((w & MASK_SOB) == CODE_SOB)
            c = I_SOB;
        else if ((w & MASK_ONE) == CODE_CLR)
            c = I_CLR;
        else if ((w & MASK_ONE) == CODE_JMP)
            c = (w[5:3] == 3'd0) ? I_UNK : I_JMP;
        else if ((w & MASK_BR) == CODE_BR)
            c = I_BR;
        else if ((w & MASK_BR) == CODE_BEQ)
            c = I_BEQ;
        else if ((w & MASK_RTS) == CODE_RTS)
            c = I_RTS;
        else if ((w & MASK_SOB) == CODE_JSR)
            c = (w[5:3] == 3'd0) ? I_UNK : I_JSR;
        else if ((w & MASK_ONE) == CODE_TSTB)
            c = I_TSTB;
        else if ((w & MASK_BR) == CODE_BPL)
            c = I_BPL;
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== sv/msc_ram.sv =====
// ----------------------------------------------------------------------------
// msc_ram: single-port RAM
// One read or write per cycle, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module msc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 1024
) (
    input  wire                      clk,
    input  wire                      we,
    input  wire  [$clog2(DEPTH)-1:0] addr,
    input  wire  [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== sv/minicomputer_instruction_subset_core.sv =====
// ----------------------------------------------------------------------------
// minicomputer_instruction_subset_core: 16-bit minicomputer subset core
// Byte memory, eight registers, condition codes; load, start and step requests.
// ----------------------------------------------------------------------------
// After reset the core sweeps the byte memory to zero, one byte per cycle,
// and takes no request meanwhile; configuration writes are accepted
// throughout. A request is taken only while the sequencer is idle, and one
// result is produced per request. Every memory byte goes through the single
// RAM port: an access first folds its address into range, subtracting
// MEMORY_BYTES once per wrap (no folding when the memory is 64 KiB); a read
// then passes S_M_RD_LO and S_M_RD_HI, a word read also S_M_RD_END, and a
// write passes S_M_WR_LO and, for a word, S_M_WR_HI. Address steps, branch
// targets and the add instruction all use the one shared adder. A stalled
// result holds the sequencer in its done state until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module minicomputer_instruction_subset_core #(
    parameter int unsigned MEMORY_BYTES = msc_pkg::MEMORY_BYTES_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    // request channel
    input  wire         in_valid,
    output logic        in_ready,
    input  wire  [1:0]  opcode,
    input  wire  [15:0] load_address,
    input  wire  [7:0]  load_data,
    // result channel
    output logic        out_valid,
    input  wire         out_ready,
    output logic [2:0]  status,
    output logic [15:0] instruction_word,
    output logic [15:0] r0_value,
    output logic [15:0] r1_value,
    output logic [15:0] r2_value,
    output logic [15:0] r3_value,
    output logic [15:0] r4_value,
    output logic [15:0] r5_value,
    output logic [15:0] stack_pointer,
    output logic [15:0] program_counter,
    output logic [3:0]  flags,
    // configuration port
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [1:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    import msc_pkg::*;

    localparam int unsigned AW        = $clog2(MEMORY_BYTES);
    localparam logic [16:0] MEM_LIMIT = 17'(MEMORY_BYTES);
    localparam logic [AW-1:0] CLR_LAST = AW'(MEMORY_BYTES - 1);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    state_t        state_reg, state_next;
    state_t        mem_ret_reg, mem_ret_next;   // return point of a memory access
    state_t        res_ret_reg, res_ret_next;   // return point of operand resolve
    instr_t        cls_reg, cls_next;

    logic [15:0]   rf_reg [8];
    logic [3:0]    cc_reg, cc_next;
    logic          halted_reg, halted_next;
    logic [15:0]   start_address_reg;
    logic [AW-1:0] clr_cnt_reg;

    logic [15:0]   ir_reg, ir_next;
    logic [5:0]    spec_reg, spec_next;
    logic          byte_reg, byte_next;
    logic          isreg_reg, isreg_next;
    logic [15:0]   opaddr_reg, opaddr_next;
    logic [15:0]   sval_reg, sval_next;
    logic [15:0]   dval_reg, dval_next;
    logic [2:0]    status_reg, status_next;
    logic [15:0]   word_reg, word_next;

    // memory access sequencer
    logic [15:0]   midx_reg, midx_next;
    logic [15:0]   mwdata_reg, mwdata_next;
    logic [15:0]   mrdata_reg, mrdata_next;
    logic          mbyte_reg, mbyte_next;
    logic          mwrite_reg, mwrite_next;

    // result register
    logic          out_valid_reg, out_valid_next;
    logic [2:0]    out_status_reg;
    logic [15:0]   out_word_reg;
    logic [15:0]   out_rf_reg [8];
    logic [3:0]    out_cc_reg;
    logic          out_load;

    // register file ports, shared adder, RAM port
    logic [2:0]    rd_sel;
    logic [15:0]   rd;
    logic          rf_we;
    logic [2:0]    rf_wsel;
    logic [15:0]   rf_wdata;
    logic [15:0]   add_a, add_b;
    logic          add_cin;
    logic [16:0]   sum;
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [7:0]    ram_wdata, ram_rdata;

    logic [2:0]    n;
    logic [2:0]    mode;
    logic [2:0]    rn;
    logic [2:0]    k;
    logic [15:0]   inc16;
    logic [16:0]   hi_sum;
    logic [15:0]   hi_idx;
    logic [15:0]   pc;
    logic [15:0]   sp;
    logic [15:0]   wval;
    logic          take;
    logic          cfg_write;

    assign n     = spec_reg[2:0];
    assign mode  = spec_reg[5:3];
    assign rn    = ir_reg[8:6];
    assign k     = ir_reg[2:0];
    assign pc    = rf_reg[7];
    assign sp    = rf_reg[6];
    assign rd    = rf_reg[rd_sel];
    // byte autoincrement and autodecrement step by one except on the stack pointer and PC
    assign inc16 = (byte_reg && (n < 3'd6)) ? 16'd1 : 16'd2;
    assign sum   = {1'b0, add_a} + {1'b0, add_b} + {16'd0, add_cin};

    // next byte index, wrapped at the memory size
    assign hi_sum = {1'b0, midx_reg} + 17'd1;
    assign hi_idx = (hi_sum == MEM_LIMIT) ? 16'd0 : hi_sum[15:0];

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr == 2'd0);
    assign prdata    = {16'd0, start_address_reg};

    // ------------------------------------------------------------------
    // Byte memory
    // ------------------------------------------------------------------
    msc_ram #(
        .WIDTH (8),
        .DEPTH (MEMORY_BYTES)
    ) u_mem (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = midx_reg[AW-1:0];
        ram_wdata = mwdata_reg[7:0];
        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_addr  = clr_cnt_reg;
                ram_wdata = 8'd0;
            end
            S_M_WR_LO:
            begin
                ram_we = 1'b1;
            end
            S_M_WR_HI:
            begin
                ram_we    = 1'b1;
                ram_wdata = mwdata_reg[15:8];
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    assign in_ready = (state_reg == S_IDLE);
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next   = state_reg;
        mem_ret_next = mem_ret_reg;
        res_ret_next = res_ret_reg;
        cls_next     = cls_reg;
        cc_next      = cc_reg;
        halted_next  = halted_reg;
        ir_next      = ir_reg;
        spec_next    = spec_reg;
        byte_next    = byte_reg;
        isreg_next   = isreg_reg;
        opaddr_next  = opaddr_reg;
        sval_next    = sval_reg;
        dval_next    = dval_reg;
        status_next  = status_reg;
        word_next    = word_reg;
        midx_next    = midx_reg;
        mwdata_next  = mwdata_reg;
        mrdata_next  = mrdata_reg;
        mbyte_next   = mbyte_reg;
        mwrite_next  = mwrite_reg;
        rd_sel       = n;
        rf_we        = 1'b0;
        rf_wsel      = 3'd7;
        rf_wdata     = sum[15:0];
        add_a        = rd;
        add_b        = 16'd2;
        add_cin      = 1'b0;
        wval         = sval_reg;
        take         = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                if (clr_cnt_reg == CLR_LAST)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    word_next = 16'd0;
                    case (opcode)
                        OP_LOAD:
                        begin
                            status_next  = ST_DONE;
                            midx_next    = load_address;
                            mwdata_next  = {8'd0, load_data};
                            mbyte_next   = 1'b1;
                            mwrite_next  = 1'b1;
                            mem_ret_next = S_DONE;
                            state_next   = S_M_MOD;
                        end
                        OP_START:
                        begin
                            status_next = ST_DONE;
                            rf_we       = 1'b1;
                            rf_wsel     = 3'd7;
                            rf_wdata    = start_address_reg;
                            halted_next = 1'b0;
                            state_next  = S_DONE;
                        end
                        OP_STEP:
                        begin
                            if (halted_reg)
                            begin
                                status_next = ST_IGNORED;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                state_next = S_FETCH;
                            end
                        end
                        default:
                        begin
                            status_next = ST_IGNORED;
                            state_next  = S_DONE;
                        end
                    endcase
                end
            end

            S_FETCH:
            begin
                // advance PC and read the instruction word at the old PC
                add_a        = pc;
                rf_we        = 1'b1;
                rf_wsel      = 3'd7;
                midx_next    = {pc[15:1], 1'b0};
                mbyte_next   = 1'b0;
                mwrite_next  = 1'b0;
                mem_ret_next = S_DECODE;
                state_next   = S_M_MOD;
            end

            S_DECODE:
            begin
                word_next   = mrdata_reg;
                ir_next     = mrdata_reg;
                cls_next    = decode_instr(mrdata_reg);
                status_next = ST_EXEC;
                byte_next   = 1'b0;
                case (decode_instr(mrdata_reg))
                    I_MOV, I_ADD, I_MOVB:
                    begin
                        byte_next    = (decode_instr(mrdata_reg) == I_MOVB);
                        spec_next    = mrdata_reg[11:6];
                        res_ret_next = S_SRC_GET;
                        state_next   = S_RES_A;
                    end
                    I_CLR, I_JMP, I_JSR, I_TSTB:
                    begin
                        byte_next    = (decode_instr(mrdata_reg) == I_TSTB);
                        spec_next    = mrdata_reg[5:0];
                        res_ret_next = S_DST_RES;
                        state_next   = S_RES_A;
                    end
                    I_HALT:
                    begin
                        halted_next = 1'b1;
                        status_next = ST_HALT;
                        state_next  = S_DONE;
                    end
                    I_SOB:
                    begin
                        state_next = S_SOB1;
                    end
                    I_BR, I_BEQ, I_BPL:
                    begin
                        state_next = S_BRANCH;
                    end
                    I_RTS:
                    begin
                        state_next = S_RTS1;
                    end
                    default:
                    begin
                        status_next = ST_UNKNOWN;
                        state_next  = S_DONE;
                    end
                endcase
            end

            // ---------------- operand resolve ----------------
            S_RES_A:
            begin
                rd_sel     = n;
                isreg_next = 1'b0;
                case (mode)
                    3'd0:
                    begin
                        isreg_next = 1'b1;
                        state_next = res_ret_reg;
                    end
                    3'd1:
                    begin
                        opaddr_next = rd;
                        state_next  = res_ret_reg;
                    end
                    3'd2:
                    begin
                        add_b       = inc16;
                        rf_we       = 1'b1;
                        rf_wsel     = n;
                        opaddr_next = rd;
                        state_next  = res_ret_reg;
                    end
                    3'd3:
                    begin
                        rf_we        = 1'b1;
                        rf_wsel      = n;
                        midx_next    = {rd[15:1], 1'b0};
                        mbyte_next   = 1'b0;
                        mwrite_next  = 1'b0;
                        mem_ret_next = S_RES_DEF;
                        state_next   = S_M_MOD;
                    end
                    3'd4:
                    begin
                        add_b       = ~inc16;
                        add_cin     = 1'b1;
                        rf_we       = 1'b1;
                        rf_wsel     = n;
                        opaddr_next = sum[15:0];
                        state_next  = res_ret_reg;
                    end
                    3'd5:
                    begin
                        add_b        = ~16'd2;
                        add_cin      = 1'b1;
                        rf_we        = 1'b1;
                        rf_wsel      = n;
                        midx_next    = {sum[15:1], 1'b0};
                        mbyte_next   = 1'b0;
                        mwrite_next  = 1'b0;
                        mem_ret_next = S_RES_DEF;
                        state_next   = S_M_MOD;
                    end
                    default:
                    begin
                        // indexed: fetch the index word and step PC past it
                        add_a        = pc;
                        rf_we        = 1'b1;
                        rf_wsel      = 3'd7;
                        midx_next    = {pc[15:1], 1'b0};
                        mbyte_next   = 1'b0;
                        mwrite_next  = 1'b0;
                        mem_ret_next = S_RES_IDX;
                        state_next   = S_M_MOD;
                    end
                endcase
            end

            S_RES_IDX:
            begin
                rd_sel = n;
                add_b  = mrdata_reg;
                if (mode == 3'd6)
                begin
                    opaddr_next = sum[15:0];
                    state_next  = res_ret_reg;
                end
                else
                begin
                    midx_next    = {sum[15:1], 1'b0};
                    mbyte_next   = 1'b0;
                    mwrite_next  = 1'b0;
                    mem_ret_next = S_RES_DEF;
                    state_next   = S_M_MOD;
                end
            end

            S_RES_DEF:
            begin
                opaddr_next = mrdata_reg;
                state_next  = res_ret_reg;
            end

            // ---------------- source value ----------------
            S_SRC_GET:
            begin
                rd_sel = n;
                if (isreg_reg)
                begin
                    sval_next  = byte_reg ? {8'd0, rd[7:0]} : rd;
                    state_next = S_DST;
                end
                else
                begin
                    midx_next    = byte_reg ? opaddr_reg : {opaddr_reg[15:1], 1'b0};
                    mbyte_next   = byte_reg;
                    mwrite_next  = 1'b0;
                    mem_ret_next = S_SRC_LATCH;
                    state_next   = S_M_MOD;
                end
            end

            S_SRC_LATCH:
            begin
                sval_next  = mrdata_reg;
                state_next = S_DST;
            end

            S_DST:
            begin
                spec_next    = ir_reg[5:0];
                res_ret_next = S_DST_RES;
                state_next   = S_RES_A;
            end

            S_DST_RES:
            begin
                case (cls_reg)
                    I_MOV, I_MOVB, I_CLR:
                    begin
                        state_next = S_WRITE;
                    end
                    I_ADD, I_TSTB:
                    begin
                        state_next = S_DST_GET;
                    end
                    I_JMP:
                    begin
                        rf_we      = 1'b1;
                        rf_wsel    = 3'd7;
                        rf_wdata   = opaddr_reg;
                        state_next = S_DONE;
                    end
                    I_JSR:
                    begin
                        state_next = S_JSR1;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            S_DST_GET:
            begin
                rd_sel = n;
                if (isreg_reg)
                begin
                    dval_next  = byte_reg ? {8'd0, rd[7:0]} : rd;
                    state_next = S_DST_USE;
                end
                else
                begin
                    midx_next    = byte_reg ? opaddr_reg : {opaddr_reg[15:1], 1'b0};
                    mbyte_next   = byte_reg;
                    mwrite_next  = 1'b0;
                    mem_ret_next = S_DST_LATCH;
                    state_next   = S_M_MOD;
                end
            end

            S_DST_LATCH:
            begin
                dval_next  = mrdata_reg;
                state_next = S_DST_USE;
            end

            S_DST_USE:
            begin
                if (cls_reg == I_ADD)
                begin
                    add_a     = sval_reg;
                    add_b     = dval_reg;
                    sval_next = sum[15:0];
                    cc_next   = {sum[15], (sum[15:0] == 16'd0),
                                 (~(sval_reg[15] ^ dval_reg[15]) & (sval_reg[15] ^ sum[15])),
                                 sum[16]};
                    state_next = S_WRITE;
                end
                else
                begin
                    cc_next    = {dval_reg[7], (dval_reg[7:0] == 8'd0), 2'b00};
                    state_next = S_DONE;
                end
            end

            S_WRITE:
            begin
                case (cls_reg)
                    I_MOV:
                    begin
                        cc_next = {sval_reg[15], (sval_reg == 16'd0), 1'b0, cc_reg[0]};
                    end
                    I_MOVB:
                    begin
                        cc_next = {sval_reg[7], (sval_reg[7:0] == 8'd0), 1'b0, cc_reg[0]};
                    end
                    I_CLR:
                    begin
                        wval    = 16'd0;
                        cc_next = 4'b0100;
                    end
                    default:
                    begin
                        wval = sval_reg;
                    end
                endcase
                if (isreg_reg)
                begin
                    rf_we      = 1'b1;
                    rf_wsel    = n;
                    // byte move into a register sign-extends
                    rf_wdata   = (cls_reg == I_MOVB) ? {{8{sval_reg[7]}}, sval_reg[7:0]}
                                                     : wval;
                    state_next = S_DONE;
                end
                else
                begin
                    midx_next    = (cls_reg == I_MOVB) ? opaddr_reg
                                                       : {opaddr_reg[15:1], 1'b0};
                    mbyte_next   = (cls_reg == I_MOVB);
                    mwrite_next  = 1'b1;
                    mwdata_next  = wval;
                    mem_ret_next = S_DONE;
                    state_next   = S_M_MOD;
                end
            end

            // ---------------- subroutine linkage ----------------
            S_JSR1:
            begin
                add_a      = sp;
                add_b      = ~16'd2;
                add_cin    = 1'b1;
                rf_we      = 1'b1;
                rf_wsel    = 3'd6;
                state_next = S_JSR2;
            end

            S_JSR2:
            begin
                rd_sel       = rn;
                midx_next    = {sp[15:1], 1'b0};
                mbyte_next   = 1'b0;
                mwrite_next  = 1'b1;
                mwdata_next  = rd;
                mem_ret_next = S_JSR3;
                state_next   = S_M_MOD;
            end

            S_JSR3:
            begin
                rf_we      = 1'b1;
                rf_wsel    = rn;
                rf_wdata   = pc;
                state_next = S_JSR4;
            end

            S_JSR4:
            begin
                rf_we      = 1'b1;
                rf_wsel    = 3'd7;
                rf_wdata   = opaddr_reg;
                state_next = S_DONE;
            end

            S_RTS1:
            begin
                rd_sel       = k;
                rf_we        = 1'b1;
                rf_wsel      = 3'd7;
                rf_wdata     = rd;
                midx_next    = {sp[15:1], 1'b0};
                mbyte_next   = 1'b0;
                mwrite_next  = 1'b0;
                mem_ret_next = S_RTS2;
                state_next   = S_M_MOD;
            end

            S_RTS2:
            begin
                rf_we      = 1'b1;
                rf_wsel    = k;
                rf_wdata   = mrdata_reg;
                state_next = S_RTS3;
            end

            S_RTS3:
            begin
                add_a      = sp;
                rf_we      = 1'b1;
                rf_wsel    = 3'd6;
                state_next = S_DONE;
            end

            // ---------------- loop and branches ----------------
            S_SOB1:
            begin
                rd_sel     = rn;
                add_b      = 16'hFFFF;
                rf_we      = 1'b1;
                rf_wsel    = rn;
                state_next = S_SOB2;
            end

            S_SOB2:
            begin
                rd_sel  = rn;
                add_a   = pc;
                add_b   = ~{9'd0, ir_reg[5:0], 1'b0};
                add_cin = 1'b1;
                rf_we   = (rd != 16'd0);
                rf_wsel = 3'd7;
                state_next = S_DONE;
            end

            S_BRANCH:
            begin
                take = (cls_reg == I_BR) || ((cls_reg == I_BEQ) && cc_reg[2])
                    || ((cls_reg == I_BPL) && !cc_reg[3]);
                add_a      = pc;
                add_b      = {{7{ir_reg[7]}}, ir_reg[7:0], 1'b0};
                rf_we      = take;
                rf_wsel    = 3'd7;
                state_next = S_DONE;
            end

            // ---------------- memory access ----------------
            S_M_MOD:
            begin
                // fold the byte address into the memory, one wrap per cycle
                if ({1'b0, midx_reg} >= MEM_LIMIT)
                begin
                    midx_next = 16'({1'b0, midx_reg} - MEM_LIMIT);
                end
                else
                begin
                    state_next = mwrite_reg ? S_M_WR_LO : S_M_RD_LO;
                end
            end

            S_M_RD_LO:
            begin
                midx_next  = hi_idx;
                state_next = S_M_RD_HI;
            end

            S_M_RD_HI:
            begin
                mrdata_next = {8'd0, ram_rdata};
                state_next  = mbyte_reg ? mem_ret_reg : S_M_RD_END;
            end

            S_M_RD_END:
            begin
                mrdata_next = {ram_rdata, mrdata_reg[7:0]};
                state_next  = mem_ret_reg;
            end

            S_M_WR_LO:
            begin
                midx_next  = hi_idx;
                state_next = mbyte_reg ? mem_ret_reg : S_M_WR_HI;
            end

            S_M_WR_HI:
            begin
                state_next = mem_ret_reg;
            end

            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_CLEAR;
            clr_cnt_reg       <= '0;
            cc_reg            <= 4'd0;
            halted_reg        <= 1'b1;
            start_address_reg <= START_RESET;
            out_valid_reg     <= 1'b0;
            mem_ret_reg       <= S_IDLE;
            res_ret_reg       <= S_IDLE;
            for (int i = 0; i < 8; i++)
            begin
                rf_reg[i] <= 16'd0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            mem_ret_reg   <= mem_ret_next;
            res_ret_reg   <= res_ret_next;
            cc_reg        <= cc_next;
            halted_reg    <= halted_next;
            out_valid_reg <= out_valid_next;
            if (state_reg == S_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cfg_write)
            begin
                start_address_reg <= pwdata[15:0];
            end
            if (rf_we)
            begin
                rf_reg[rf_wsel] <= rf_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cls_reg    <= cls_next;
        ir_reg     <= ir_next;
        spec_reg   <= spec_next;
        byte_reg   <= byte_next;
        isreg_reg  <= isreg_next;
        opaddr_reg <= opaddr_next;
        sval_reg   <= sval_next;
        dval_reg   <= dval_next;
        status_reg <= status_next;
        word_reg   <= word_next;
        midx_reg   <= midx_next;
        mwdata_reg <= mwdata_next;
        mrdata_reg <= mrdata_next;
        mbyte_reg  <= mbyte_next;
        mwrite_reg <= mwrite_next;
        // hold a snapshot of the machine state for the result
        if (out_load)
        begin
            out_status_reg <= status_reg;
            out_word_reg   <= word_reg;
            out_cc_reg     <= cc_reg;
            for (int i = 0; i < 8; i++)
            begin
                out_rf_reg[i] <= rf_reg[i];
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign status           = out_status_reg;
    assign instruction_word = out_word_reg;
    assign r0_value         = out_rf_reg[0];
    assign r1_value         = out_rf_reg[1];
    assign r2_value         = out_rf_reg[2];
    assign r3_value         = out_rf_reg[3];
    assign r4_value         = out_rf_reg[4];
    assign r5_value         = out_rf_reg[5];
    assign stack_pointer    = out_rf_reg[6];
    assign program_counter  = out_rf_reg[7];
    assign flags            = out_cc_reg;

`ifndef NO_ASSERTIONS
    // an accepted request drops in_ready, so no request is taken back to back
    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request accepted back to back");

    // a RAM access only starts once the address is folded into range
    a_addr_folded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_M_RD_LO || state_reg == S_M_WR_LO)
            |-> ({1'b0, midx_reg} < MEM_LIMIT))
        else $error("memory index out of range");

    // a halt result always leaves the core halted
    a_halt_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && status_reg == ST_HALT) |-> halted_reg)
        else $error("halt without halted flag");

    // no request while the clearing sweep runs
    a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !in_ready)
        else $error("request taken during clear");
`endif

endmodule

`default_nettype wire
